@@ rtl/mbfb_pkg.sv @@
// Shared constants, types and control structures of the memory bus with bitmap framebuffer.
package mbfb_pkg;

  // Default sizes of the memories and of the screen.
  localparam int RAM_BYTES_DEF     = 65536;
  localparam int VRAM_BYTES_DEF    = 16384;
  localparam int ROM_BYTES_DEF     = 65536;
  localparam int SCREEN_WIDTH_DEF  = 640;
  localparam int SCREEN_HEIGHT_DEF = 200;
  localparam int ROW_BYTES_DEF     = 80;

  // Field widths.
  localparam int ADDR_W     = 20;
  localparam int PORT_W     = 16;
  localparam int BYTE_W     = 8;
  localparam int COORD_W    = 12;
  localparam int CMD_W      = 3;
  localparam int CFG_IW     = 3;
  localparam int CFG_DW     = 20;
  // Pixel byte index: an 11-bit row times a row length of up to 1024, plus a column byte.
  localparam int PIX_W      = 21;
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 24;

  // Register reset values.
  localparam logic [ADDR_W-1:0] ADDR_MASK_RST  = 20'hFFFFF;
  localparam logic [ADDR_W-1:0] RAM_START_RST  = 20'h00000;
  localparam logic [ADDR_W-1:0] VRAM_START_RST = 20'hB8000;
  localparam logic [ADDR_W-1:0] ROM_START_RST  = 20'hF0000;
  localparam logic [PORT_W-1:0] DBG_PORT_RST   = 16'h00E9;

  // Byte constants.
  localparam logic [BYTE_W-1:0] BYTE_ONES = 8'hFF;
  localparam logic [BYTE_W-1:0] BYTE_ZERO = 8'h00;
  localparam logic [BYTE_W-1:0] PIX_MSB   = 8'h80;

  // Configuration register indexes.
  localparam logic [CFG_IW-1:0] CFG_ADDR_MASK  = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_RAM_START  = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_VRAM_START = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_ROM_START  = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_DBG_PORT   = 3'd4;

  // Bus commands.
  typedef enum logic [CMD_W-1:0] {
    CMD_MEM_RD   = 3'd0,
    CMD_MEM_WR   = 3'd1,
    CMD_IO_RD    = 3'd2,
    CMD_IO_WR    = 3'd3,
    CMD_ROM_LOAD = 3'd4,
    CMD_PIX_WR   = 3'd5,
    CMD_PIX_RD   = 3'd6,
    CMD_FILL     = 3'd7
  } cmd_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic decode;
    logic access;
    logic modify;
    logic clear;
    logic fill;
    logic load_out;
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    cmd_t cmd;
    logic clear_last;
    logic fill_last;
    logic out_free;
  } stat_t;

endpackage

@@ rtl/mbfb_ram.sv @@
// Generic single-port RAM with one write port and a registered read.
module mbfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write and registered read at the same address.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/mbfb_ctrl.sv @@
// Controller state machine that sequences reset clearing, bus transactions and screen fills.
module mbfb_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  mbfb_pkg::stat_t stat,
  output mbfb_pkg::ctrl_t ctl
);

  typedef enum logic [6:0] {
    ST_CLEAR  = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_DECODE = 7'b0000100,
    ST_ACCESS = 7'b0001000,
    ST_MODIFY = 7'b0010000,
    ST_FILL   = 7'b0100000,
    ST_DONE   = 7'b1000000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_tready = (state_r == ST_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    case (state_r)
      ST_CLEAR: begin
        ctl.clear = 1'b1;
        if (stat.clear_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        ctl.capture = in_tvalid;
        if (in_tvalid) begin
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        ctl.decode = 1'b1;
        state_nxt  = ST_ACCESS;
      end
      ST_ACCESS: begin
        ctl.access = 1'b1;
        case (stat.cmd)
          mbfb_pkg::CMD_PIX_WR: state_nxt = ST_MODIFY;
          mbfb_pkg::CMD_FILL:   state_nxt = ST_FILL;
          default:              state_nxt = ST_DONE;
        endcase
      end
      ST_MODIFY: begin
        ctl.modify = 1'b1;
        state_nxt  = ST_DONE;
      end
      ST_FILL: begin
        ctl.fill = 1'b1;
        if (stat.fill_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        ctl.load_out = stat.out_free;
        if (stat.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ rtl/mbfb_dp.sv @@
// Datapath: configuration registers, address decode, pixel addressing, memories and result register.
module mbfb_dp #(
  parameter int RAM_BYTES     = mbfb_pkg::RAM_BYTES_DEF,
  parameter int VRAM_BYTES    = mbfb_pkg::VRAM_BYTES_DEF,
  parameter int ROM_BYTES     = mbfb_pkg::ROM_BYTES_DEF,
  parameter int SCREEN_WIDTH  = mbfb_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = mbfb_pkg::SCREEN_HEIGHT_DEF,
  parameter int ROW_BYTES     = mbfb_pkg::ROW_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [mbfb_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [mbfb_pkg::CMD_W-1:0]      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [mbfb_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                            out_tuser,
  input  logic                            cfg_we,
  input  logic [mbfb_pkg::CFG_IW-1:0]     cfg_index,
  input  logic [mbfb_pkg::CFG_DW-1:0]     cfg_wdata,
  input  mbfb_pkg::ctrl_t                 ctl,
  output mbfb_pkg::stat_t                 stat
);

  localparam int RAM_AW   = $clog2(RAM_BYTES);
  localparam int VRAM_AW  = $clog2(VRAM_BYTES);
  localparam int ROM_AW   = $clog2(ROM_BYTES);
  localparam int MAX_AB   = (RAM_BYTES > ROM_BYTES) ? RAM_BYTES : ROM_BYTES;
  localparam int MAX_BYTES = (MAX_AB > VRAM_BYTES) ? MAX_AB : VRAM_BYTES;
  localparam int SWP_AW   = $clog2(MAX_BYTES);
  localparam int AW       = mbfb_pkg::ADDR_W;
  localparam int BW       = mbfb_pkg::BYTE_W;
  localparam int PW       = mbfb_pkg::PIX_W;

  // Configuration registers.
  logic [AW-1:0]               addr_mask_r;
  logic [AW-1:0]               ram_start_r;
  logic [AW-1:0]               vram_start_r;
  logic [AW-1:0]               rom_start_r;
  logic [mbfb_pkg::PORT_W-1:0] dbg_port_r;

  // Captured transaction.
  mbfb_pkg::cmd_t                    cmd_r;
  logic [AW-1:0]                     addr_r;
  logic [mbfb_pkg::PORT_W-1:0]       port_r;
  logic [BW-1:0]                     data_r;
  logic signed [mbfb_pkg::COORD_W-1:0] px_r;
  logic signed [mbfb_pkg::COORD_W-1:0] py_r;
  logic                              on_r;

  // Decode results.
  logic               sel_ram_r;
  logic               sel_vram_r;
  logic               sel_rom_r;
  logic [RAM_AW-1:0]  ram_off_r;
  logic [VRAM_AW-1:0] vram_off_r;
  logic [ROM_AW-1:0]  rom_off_r;
  logic               rom_load_ok_r;
  logic               dbg_hit_r;
  logic               pix_ok_r;
  logic [VRAM_AW-1:0] pix_idx_r;
  logic [BW-1:0]      pix_mask_r;

  // Sweep counter for the reset clearing pass and the screen fill.
  logic [SWP_AW-1:0] sweep_r;

  // Result register.
  logic          out_valid_r;
  logic [BW-1:0] rd_r;
  logic          pv_r;
  logic          dv_r;
  logic [BW-1:0] dc_r;

  // Combinational decode signals.
  logic [AW-1:0] masked;
  logic [AW:0]   ram_diff;
  logic [AW:0]   vram_diff;
  logic [AW:0]   rom_diff;
  logic          hit_ram;
  logic          hit_vram;
  logic          hit_rom;
  logic          in_screen;
  logic [PW-1:0] pix_prod;
  logic [PW-1:0] pix_idx;

  // Memory ports.
  logic               ram_we;
  logic [RAM_AW-1:0]  ram_addr;
  logic [BW-1:0]      ram_wdata;
  logic [BW-1:0]      ram_q;
  logic               vram_we;
  logic [VRAM_AW-1:0] vram_addr;
  logic [BW-1:0]      vram_wdata;
  logic [BW-1:0]      vram_q;
  logic               rom_we;
  logic [ROM_AW-1:0]  rom_addr;
  logic [BW-1:0]      rom_wdata;
  logic [BW-1:0]      rom_q;
  logic               pix_cmd;

  // Result values.
  logic [BW-1:0] rd_nxt;
  logic          pv_nxt;
  logic          dv_nxt;

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_mask_r  <= mbfb_pkg::ADDR_MASK_RST;
      ram_start_r  <= mbfb_pkg::RAM_START_RST;
      vram_start_r <= mbfb_pkg::VRAM_START_RST;
      rom_start_r  <= mbfb_pkg::ROM_START_RST;
      dbg_port_r   <= mbfb_pkg::DBG_PORT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        mbfb_pkg::CFG_ADDR_MASK:  addr_mask_r  <= cfg_wdata;
        mbfb_pkg::CFG_RAM_START:  ram_start_r  <= cfg_wdata;
        mbfb_pkg::CFG_VRAM_START: vram_start_r <= cfg_wdata;
        mbfb_pkg::CFG_ROM_START:  rom_start_r  <= cfg_wdata;
        mbfb_pkg::CFG_DBG_PORT:   dbg_port_r   <= cfg_wdata[mbfb_pkg::PORT_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture the input transaction.
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_r  <= mbfb_pkg::cmd_t'(in_tuser);
      addr_r <= in_tdata[19:0];
      port_r <= in_tdata[35:20];
      data_r <= in_tdata[43:36];
      px_r   <= in_tdata[55:44];
      py_r   <= in_tdata[67:56];
      on_r   <= in_tdata[68];
    end
  end

  // Window decode of the masked address.
  assign masked    = addr_r & addr_mask_r;
  assign ram_diff  = {1'b0, masked} - {1'b0, ram_start_r};
  assign vram_diff = {1'b0, masked} - {1'b0, vram_start_r};
  assign rom_diff  = {1'b0, masked} - {1'b0, rom_start_r};
  assign hit_ram   = !ram_diff[AW] && (ram_diff[AW-1:0] < AW'(RAM_BYTES));
  assign hit_vram  = !vram_diff[AW] && (vram_diff[AW-1:0] < AW'(VRAM_BYTES));
  assign hit_rom   = !rom_diff[AW] && (rom_diff[AW-1:0] < AW'(ROM_BYTES));

  // Pixel byte index: row times row length plus column byte.
  assign in_screen = !px_r[11] && (px_r[10:0] < 11'(SCREEN_WIDTH)) &&
                     !py_r[11] && (py_r[10:0] < 11'(SCREEN_HEIGHT));
  assign pix_prod  = PW'(py_r[10:0]) * PW'(ROW_BYTES);
  assign pix_idx   = pix_prod + PW'(px_r[10:3]);

  // Decode stage registers.
  always_ff @(posedge clk) begin
    if (ctl.decode) begin
      sel_ram_r     <= hit_ram;
      sel_vram_r    <= !hit_ram && hit_vram;
      sel_rom_r     <= !hit_ram && !hit_vram && hit_rom;
      ram_off_r     <= ram_diff[RAM_AW-1:0];
      vram_off_r    <= vram_diff[VRAM_AW-1:0];
      rom_off_r     <= rom_diff[ROM_AW-1:0];
      rom_load_ok_r <= addr_r < AW'(ROM_BYTES);
      dbg_hit_r     <= port_r == dbg_port_r;
      pix_ok_r      <= in_screen && (pix_idx < PW'(VRAM_BYTES));
      pix_idx_r     <= pix_idx[VRAM_AW-1:0];
      pix_mask_r    <= mbfb_pkg::PIX_MSB >> px_r[2:0];
    end
  end

  // Sweep counter, shared by the clearing pass and the screen fill.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r <= '0;
    end else if ((ctl.clear && stat.clear_last) || (ctl.fill && stat.fill_last)) begin
      sweep_r <= '0;
    end else if (ctl.clear || ctl.fill) begin
      sweep_r <= sweep_r + 1'b1;
    end
  end

  assign pix_cmd = (cmd_r == mbfb_pkg::CMD_PIX_WR) || (cmd_r == mbfb_pkg::CMD_PIX_RD);

  // Main RAM port.
  assign ram_addr  = ctl.clear ? sweep_r[RAM_AW-1:0] : ram_off_r;
  assign ram_wdata = ctl.clear ? mbfb_pkg::BYTE_ZERO : data_r;
  assign ram_we    = (ctl.clear && (32'(sweep_r) < RAM_BYTES)) ||
                     (ctl.access && (cmd_r == mbfb_pkg::CMD_MEM_WR) && sel_ram_r);

  // Video RAM port: clearing, fill, bus write and pixel read-modify-write.
  always_comb begin
    if (ctl.clear || ctl.fill) begin
      vram_addr = sweep_r[VRAM_AW-1:0];
    end else if (pix_cmd) begin
      vram_addr = pix_idx_r;
    end else begin
      vram_addr = vram_off_r;
    end
    if (ctl.clear) begin
      vram_wdata = mbfb_pkg::BYTE_ZERO;
    end else if (ctl.fill) begin
      vram_wdata = on_r ? mbfb_pkg::BYTE_ONES : mbfb_pkg::BYTE_ZERO;
    end else if (ctl.modify) begin
      vram_wdata = on_r ? (vram_q | pix_mask_r) : (vram_q & ~pix_mask_r);
    end else begin
      vram_wdata = data_r;
    end
  end

  assign vram_we = ((ctl.clear || ctl.fill) && (32'(sweep_r) < VRAM_BYTES)) ||
                   (ctl.access && (cmd_r == mbfb_pkg::CMD_MEM_WR) && sel_vram_r) ||
                   (ctl.modify && pix_ok_r);

  // Boot ROM port: cleared to all ones, written only by the load command.
  always_comb begin
    if (ctl.clear) begin
      rom_addr = sweep_r[ROM_AW-1:0];
    end else if (cmd_r == mbfb_pkg::CMD_ROM_LOAD) begin
      rom_addr = addr_r[ROM_AW-1:0];
    end else begin
      rom_addr = rom_off_r;
    end
  end

  assign rom_wdata = ctl.clear ? mbfb_pkg::BYTE_ONES : data_r;
  assign rom_we    = (ctl.clear && (32'(sweep_r) < ROM_BYTES)) ||
                     (ctl.access && (cmd_r == mbfb_pkg::CMD_ROM_LOAD) && rom_load_ok_r);

  mbfb_ram #(.WIDTH(BW), .DEPTH(RAM_BYTES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_q)
  );

  mbfb_ram #(.WIDTH(BW), .DEPTH(VRAM_BYTES)) u_vram (
    .clk   (clk),
    .we    (vram_we),
    .addr  (vram_addr),
    .wdata (vram_wdata),
    .rdata (vram_q)
  );

  mbfb_ram #(.WIDTH(BW), .DEPTH(ROM_BYTES)) u_rom (
    .clk   (clk),
    .we    (rom_we),
    .addr  (rom_addr),
    .wdata (rom_wdata),
    .rdata (rom_q)
  );

  // Result values from the read data and decode flags.
  always_comb begin
    case (cmd_r)
      mbfb_pkg::CMD_MEM_RD: begin
        if (sel_ram_r) begin
          rd_nxt = ram_q;
        end else if (sel_vram_r) begin
          rd_nxt = vram_q;
        end else if (sel_rom_r) begin
          rd_nxt = rom_q;
        end else begin
          rd_nxt = mbfb_pkg::BYTE_ONES;
        end
      end
      mbfb_pkg::CMD_IO_RD: rd_nxt = mbfb_pkg::BYTE_ONES;
      default:             rd_nxt = mbfb_pkg::BYTE_ZERO;
    endcase
  end

  assign pv_nxt = (cmd_r == mbfb_pkg::CMD_PIX_RD) && pix_ok_r && |(vram_q & pix_mask_r);
  assign dv_nxt = (cmd_r == mbfb_pkg::CMD_IO_WR) && dbg_hit_r;

  // Output register; a new result loads only when the previous one is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      rd_r <= rd_nxt;
      pv_r <= pv_nxt;
      dv_r <= dv_nxt;
      dc_r <= dv_nxt ? data_r : mbfb_pkg::BYTE_ZERO;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, dc_r, pv_r, rd_r};
  assign out_tuser  = dv_r;

  // Status to the controller.
  assign stat.cmd        = cmd_r;
  assign stat.clear_last = sweep_r == SWP_AW'(MAX_BYTES - 1);
  assign stat.fill_last  = sweep_r == SWP_AW'(VRAM_BYTES - 1);
  assign stat.out_free   = !out_valid_r || out_tready;

endmodule

@@ rtl/memory_bus_with_bitmap_framebuffer_core.sv @@
// Top level of the byte memory bus with RAM, video RAM framebuffer and boot ROM.
// Byte memory bus of an 8088-class machine: each memory address is masked and decoded into
// the RAM, video RAM and boot ROM windows (RAM first, then video RAM, then ROM); unmapped
// reads give 0xFF, IO reads give 0xFF and an IO write to the debug port returns the byte
// with debug_valid set. Video RAM also holds a 1-bit-per-pixel MSB-first framebuffer with
// pixel write, pixel read and whole-screen fill. Every transaction yields one result.
// After reset the block runs a clearing pass over max(RAM_BYTES, VRAM_BYTES, ROM_BYTES)
// addresses (65536 by default) with in_tready low; configuration writes are taken meanwhile.
// Transactions are handled one at a time, through the decode and access states, with a
// modify state for a pixel write (read-modify-write of one byte) and a fill state for a
// screen fill, which writes one video RAM byte per cycle. The output register holds a
// finished result while the next transaction is accepted.
module memory_bus_with_bitmap_framebuffer_core #(
  parameter int RAM_BYTES     = mbfb_pkg::RAM_BYTES_DEF,
  parameter int VRAM_BYTES    = mbfb_pkg::VRAM_BYTES_DEF,
  parameter int ROM_BYTES     = mbfb_pkg::ROM_BYTES_DEF,
  parameter int SCREEN_WIDTH  = mbfb_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = mbfb_pkg::SCREEN_HEIGHT_DEF,
  parameter int ROW_BYTES     = mbfb_pkg::ROW_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // address[19:0], port[35:20], data[43:36], pixel_x[55:44], pixel_y[67:56], pixel_on[68]
  input  logic [mbfb_pkg::IN_DATA_W-1:0]  in_tdata,
  // command[2:0]
  input  logic [mbfb_pkg::CMD_W-1:0]      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // read_data[7:0], pixel_value[8], debug_char[16:9]
  output logic [mbfb_pkg::OUT_DATA_W-1:0] out_tdata,
  // debug_valid[0]
  output logic                            out_tuser,
  input  logic                            cfg_we,
  input  logic [mbfb_pkg::CFG_IW-1:0]     cfg_index,
  input  logic [mbfb_pkg::CFG_DW-1:0]     cfg_wdata
);

  mbfb_pkg::ctrl_t ctl;
  mbfb_pkg::stat_t stat;

  mbfb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .ctl       (ctl)
  );

  mbfb_dp #(
    .RAM_BYTES     (RAM_BYTES),
    .VRAM_BYTES    (VRAM_BYTES),
    .ROM_BYTES     (ROM_BYTES),
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .ROW_BYTES     (ROW_BYTES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .ctl        (ctl),
    .stat       (stat)
  );

endmodule

@@ verif/mbfb_checker.sv @@
// Checker for the memory bus core: snoops all channels, predicts each result and compares.
module mbfb_checker #(
  parameter int RAM_BYTES     = mbfb_pkg::RAM_BYTES_DEF,
  parameter int VRAM_BYTES    = mbfb_pkg::VRAM_BYTES_DEF,
  parameter int ROM_BYTES     = mbfb_pkg::ROM_BYTES_DEF,
  parameter int SCREEN_WIDTH  = mbfb_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = mbfb_pkg::SCREEN_HEIGHT_DEF,
  parameter int ROW_BYTES     = mbfb_pkg::ROW_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [mbfb_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [mbfb_pkg::CMD_W-1:0]      in_tuser,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [mbfb_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                            out_tuser,
  input  logic                            cfg_we,
  input  logic [mbfb_pkg::CFG_IW-1:0]     cfg_index,
  input  logic [mbfb_pkg::CFG_DW-1:0]     cfg_wdata,
  output int                              fail_count,
  output int                              pending
);
  import mbfb_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0] read_data;
    logic              pixel_value;
    logic              debug_valid;
    logic [BYTE_W-1:0] debug_char;
  } bus_result_t;

  // Shadow copies of the memories and of the bus map.
  logic [BYTE_W-1:0] ram_shadow  [RAM_BYTES];
  logic [BYTE_W-1:0] vram_shadow [VRAM_BYTES];
  logic [BYTE_W-1:0] rom_shadow  [ROM_BYTES];
  logic [ADDR_W-1:0] addr_mask;
  logic [ADDR_W-1:0] ram_start;
  logic [ADDR_W-1:0] vram_start;
  logic [ADDR_W-1:0] rom_start;
  logic [PORT_W-1:0] dbg_port;

  // Results still owed by the block, oldest first.
  bus_result_t owed_results [$];

  function automatic bit hits_window(input int unsigned a, input int unsigned base,
                                     input int unsigned size);
    return a >= base && (a - base) < size;
  endfunction

  // Finds the byte and bit of a pixel; returns 0 when the pixel is off screen or past the video RAM.
  function automatic bit locate_pixel(input logic [COORD_W-1:0] x_raw,
                                      input logic [COORD_W-1:0] y_raw,
                                      output int unsigned byte_idx,
                                      output logic [BYTE_W-1:0] bit_mask);
    int x;
    int y;
    x = $signed(x_raw);
    y = $signed(y_raw);
    byte_idx = 0;
    bit_mask = BYTE_ZERO;
    if (x < 0 || x >= SCREEN_WIDTH || y < 0 || y >= SCREEN_HEIGHT) return 1'b0;
    byte_idx = y * ROW_BYTES + x / 8;
    if (byte_idx >= VRAM_BYTES) return 1'b0;
    bit_mask = PIX_MSB >> (x % 8);
    return 1'b1;
  endfunction

  // Applies one bus transaction to the shadow state and forms its result.
  task automatic apply_bus_access(input cmd_t cmd, input logic [IN_DATA_W-1:0] d,
                                  output bus_result_t res);
    logic [ADDR_W-1:0] a;
    logic [BYTE_W-1:0] wbyte;
    logic              on;
    int unsigned       idx;
    logic [BYTE_W-1:0] msk;
    a     = d[19:0] & addr_mask;
    wbyte = d[43:36];
    on    = d[68];
    res   = '0;
    case (cmd)
      CMD_MEM_RD: begin
        if (hits_window(a, ram_start, RAM_BYTES)) res.read_data = ram_shadow[a - ram_start];
        else if (hits_window(a, vram_start, VRAM_BYTES))
          res.read_data = vram_shadow[a - vram_start];
        else if (hits_window(a, rom_start, ROM_BYTES))
          res.read_data = rom_shadow[a - rom_start];
        else res.read_data = BYTE_ONES;
      end
      CMD_MEM_WR: begin
        if (hits_window(a, ram_start, RAM_BYTES)) ram_shadow[a - ram_start] = wbyte;
        else if (hits_window(a, vram_start, VRAM_BYTES)) vram_shadow[a - vram_start] = wbyte;
      end
      CMD_IO_RD: begin
        res.read_data = BYTE_ONES;
      end
      CMD_IO_WR: begin
        if (d[35:20] == dbg_port) begin
          res.debug_valid = 1'b1;
          res.debug_char  = wbyte;
        end
      end
      CMD_ROM_LOAD: begin
        // The load offset is not masked and must fall inside the ROM.
        if (d[19:0] < ROM_BYTES) rom_shadow[d[19:0]] = wbyte;
      end
      CMD_PIX_WR: begin
        if (locate_pixel(d[55:44], d[67:56], idx, msk))
          vram_shadow[idx] = on ? (vram_shadow[idx] | msk) : (vram_shadow[idx] & ~msk);
      end
      CMD_PIX_RD: begin
        if (locate_pixel(d[55:44], d[67:56], idx, msk))
          res.pixel_value = |(vram_shadow[idx] & msk);
      end
      default: begin
        foreach (vram_shadow[i]) vram_shadow[i] = on ? BYTE_ONES : BYTE_ZERO;
      end
    endcase
  endtask

  // Snoop every channel at the rising edge.
  always @(posedge clk) begin : snoop
    bus_result_t got;
    bus_result_t want;
    if (!rst_n) begin
      foreach (ram_shadow[i]) ram_shadow[i] = BYTE_ZERO;
      foreach (vram_shadow[i]) vram_shadow[i] = BYTE_ZERO;
      foreach (rom_shadow[i]) rom_shadow[i] = BYTE_ONES;
      addr_mask  = ADDR_MASK_RST;
      ram_start  = RAM_START_RST;
      vram_start = VRAM_START_RST;
      rom_start  = ROM_START_RST;
      dbg_port   = DBG_PORT_RST;
      fail_count = 0;
      owed_results.delete();
    end else begin
      // Register writes.
      if (cfg_we) begin
        case (cfg_index)
          CFG_ADDR_MASK:  addr_mask  = cfg_wdata;
          CFG_RAM_START:  ram_start  = cfg_wdata;
          CFG_VRAM_START: vram_start = cfg_wdata;
          CFG_ROM_START:  rom_start  = cfg_wdata;
          CFG_DBG_PORT:   dbg_port   = cfg_wdata[PORT_W-1:0];
          default: ;
        endcase
      end

      // Compare a delivered result against the oldest one owed.
      if (out_tvalid && out_tready) begin
        got.read_data   = out_tdata[7:0];
        got.pixel_value = out_tdata[8];
        got.debug_char  = out_tdata[16:9];
        got.debug_valid = out_tuser;
        if (owed_results.size() == 0) begin
          $error("result with none owed: read_data %02h pixel_value %0b debug %0b/%02h",
                 got.read_data, got.pixel_value, got.debug_valid, got.debug_char);
          fail_count++;
        end else begin
          want = owed_results.pop_front();
          if (got.read_data !== want.read_data) begin
            $error("read_data: expected %02h, actual %02h", want.read_data, got.read_data);
            fail_count++;
          end
          if (got.pixel_value !== want.pixel_value) begin
            $error("pixel_value: expected %0b, actual %0b", want.pixel_value, got.pixel_value);
            fail_count++;
          end
          if (got.debug_valid !== want.debug_valid) begin
            $error("debug_valid: expected %0b, actual %0b", want.debug_valid, got.debug_valid);
            fail_count++;
          end
          if (got.debug_char !== want.debug_char) begin
            $error("debug_char: expected %02h, actual %02h", want.debug_char, got.debug_char);
            fail_count++;
          end
        end
      end

      // Predict the result of an accepted transaction.
      if (in_tvalid && in_tready) begin
        apply_bus_access(cmd_t'(in_tuser), in_tdata, want);
        owed_results.push_back(want);
      end
    end
    pending = owed_results.size();
  end

endmodule

@@ verif/tb.sv @@
// Top of the memory bus testbench: clock, reset, bus maps, transaction stimulus and verdict.
module tb;
  import mbfb_pkg::*;

  localparam int CYCLE_LIMIT      = 2000000;
  localparam int SINK_HOLD_CYCLES = 400;
  localparam int IDLE_PCT         = 11;
  localparam int FILL_BUDGET      = 12;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [CMD_W-1:0]      in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  cfg_we;
  logic [CFG_IW-1:0]     cfg_index;
  logic [CFG_DW-1:0]     cfg_wdata;
  int                    fail_count;
  int                    pending;

  // Current bus map, kept only to aim addresses at the windows.
  logic [ADDR_W-1:0] map_ram_start;
  logic [ADDR_W-1:0] map_vram_start;
  logic [ADDR_W-1:0] map_rom_start;
  logic [PORT_W-1:0] map_dbg_port;

  bit src_idle_en;
  bit sink_idle_en;
  int sink_hold_reqs;
  int sink_hold_served;
  int sink_hold_left;
  int fills_left;
  int bus_maps;
  int cmd_count [8];
  int cycle_count;

  memory_bus_with_bitmap_framebuffer_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  mbfb_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run limit.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) @(posedge clk) cycle_count++;
    $display("TB_ERROR");
    $finish;
  end

  // Result receiver: random stalls, plus a long hold-off on request.
  initial begin
    out_tready = 1'b0;
    sink_hold_served = 0;
    sink_hold_left = 0;
    forever begin
      @(negedge clk);
      if (sink_hold_served != sink_hold_reqs) begin
        sink_hold_served++;
        sink_hold_left = SINK_HOLD_CYCLES;
      end
      if (sink_hold_left > 0) begin
        sink_hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= !(sink_idle_en && $urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  // Offers one transaction, with random idle cycles first, and waits for acceptance.
  task automatic send_access(input cmd_t cmd, input logic [ADDR_W-1:0] addr,
                             input logic [PORT_W-1:0] port, input logic [BYTE_W-1:0] data,
                             input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py,
                             input logic on);
    @(negedge clk);
    while (src_idle_en && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {3'b000, on, py, px, data, port, addr};
    cmd_count[cmd]++;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Stops offering and waits until every owed result has been delivered.
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Installs a new bus map once the block has gone idle.
  task automatic set_bus_map(input logic [ADDR_W-1:0] mask, input logic [ADDR_W-1:0] ram,
                             input logic [ADDR_W-1:0] vram, input logic [ADDR_W-1:0] rom,
                             input logic [PORT_W-1:0] dbg);
    drain_results();
    write_reg(CFG_ADDR_MASK, mask);
    write_reg(CFG_RAM_START, ram);
    write_reg(CFG_VRAM_START, vram);
    write_reg(CFG_ROM_START, rom);
    write_reg(CFG_DBG_PORT, {4'h0, dbg});
    map_ram_start  = ram;
    map_vram_start = vram;
    map_rom_start  = rom;
    map_dbg_port   = dbg;
    bus_maps++;
  endtask

  // Offsets mostly in a small hot pool or at the top edge, so reads find earlier writes.
  function automatic int unsigned pick_offset(input int unsigned size);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom_range(0, 31);
    if (r < 8) return size - 1 - $urandom_range(0, 3);
    return $urandom_range(0, size - 1);
  endfunction

  // Random transactions aimed at the windows, the pixel grid and the debug port.
  task automatic run_random(input int n_items);
    cmd_t               cmd;
    int unsigned        sel;
    int unsigned        r;
    logic [ADDR_W-1:0]  addr;
    logic [PORT_W-1:0]  port;
    logic [BYTE_W-1:0]  data;
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    logic               on;
    repeat (n_items) begin
      // Every field starts random; unused fields stay as noise.
      addr = $urandom;
      port = $urandom;
      data = $urandom;
      px   = $urandom;
      py   = $urandom;
      on   = $urandom;
      sel  = $urandom_range(0, 99);
      if (sel < 24) cmd = CMD_MEM_RD;
      else if (sel < 46) cmd = CMD_MEM_WR;
      else if (sel < 51) cmd = CMD_IO_RD;
      else if (sel < 61) cmd = CMD_IO_WR;
      else if (sel < 71) cmd = CMD_ROM_LOAD;
      else if (sel < 85) cmd = CMD_PIX_WR;
      else if (sel < 99 || fills_left == 0) cmd = CMD_PIX_RD;
      else begin
        cmd = CMD_FILL;
        fills_left--;
      end

      case (cmd)
        CMD_MEM_RD, CMD_MEM_WR: begin
          r = $urandom_range(0, 3);
          if (r == 0) addr = map_ram_start + ADDR_W'(pick_offset(RAM_BYTES_DEF));
          else if (r == 1) addr = map_vram_start + ADDR_W'(pick_offset(VRAM_BYTES_DEF));
          else if (r == 2) addr = map_rom_start + ADDR_W'(pick_offset(ROM_BYTES_DEF));
        end
        CMD_IO_WR: begin
          if ($urandom_range(0, 1) == 0) port = map_dbg_port;
        end
        CMD_ROM_LOAD: begin
          if ($urandom_range(0, 9) < 9) addr = ADDR_W'(pick_offset(ROM_BYTES_DEF));
        end
        CMD_PIX_WR, CMD_PIX_RD: begin
          r = $urandom_range(0, 19);
          if (r < 14) begin
            px = ($urandom_range(0, 2) != 0) ? COORD_W'($urandom_range(0, 23))
                                             : COORD_W'(SCREEN_WIDTH_DEF - 1 - $urandom_range(0, 7));
            py = ($urandom_range(0, 4) != 0) ? COORD_W'($urandom_range(0, 3))
                                             : COORD_W'(SCREEN_HEIGHT_DEF - 1);
          end else if (r < 17) begin
            px = COORD_W'($urandom_range(0, SCREEN_WIDTH_DEF - 1));
            py = COORD_W'($urandom_range(0, SCREEN_HEIGHT_DEF - 1));
          end
        end
        default: ;
      endcase
      send_access(cmd, addr, port, data, px, py, on);
    end
  endtask

  // Stimulus and verdict.
  initial begin
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = CMD_MEM_RD;
    cfg_we       = 1'b0;
    cfg_index    = CFG_ADDR_MASK;
    cfg_wdata    = '0;
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    sink_hold_reqs = 0;
    fills_left   = FILL_BUDGET;
    bus_maps     = 1;
    map_ram_start  = RAM_START_RST;
    map_vram_start = VRAM_START_RST;
    map_rom_start  = ROM_START_RST;
    map_dbg_port   = DBG_PORT_RST;
    foreach (cmd_count[i]) cmd_count[i] = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed checks on the reset bus map.
    send_access(CMD_MEM_RD,   20'h00000, 16'h0000, 8'h00, 12'h000, 12'h000, 1'b0);
    send_access(CMD_MEM_WR,   20'h00000, 16'h0000, 8'hA5, 12'h000, 12'h000, 1'b0);
    send_access(CMD_MEM_RD,   20'h00000, 16'h0000, 8'h00, 12'h000, 12'h000, 1'b0);
    send_access(CMD_MEM_WR,   20'h0FFFF, 16'h0000, 8'h5A, 12'h000, 12'h000, 1'b0);
    send_access(CMD_MEM_RD,   20'h0FFFF, 16'h0000, 8'h00, 12'h000, 12'h000, 1'b0);
    // Unmapped space: reads give all ones, writes are dropped.
    send_access(CMD_MEM_WR,   20'h10000, 16'h0000, 8'h77, 12'h000, 12'h000, 1'b0);
    send_access(CMD_MEM_RD,   20'h10000, 16'h0000, 8'h00, 12'h000, 12'h000, 1'b0);
    // ROM: erased contents, loads, a load past the end and a dropped bus write.
    send_access(CMD_MEM_RD,   20'hF0000, 16'h0000, 8'h00, 12'h000, 12'h000, 1'b0);
    send_access(CMD_ROM_LOAD, 20'h00000, 16'h0000, 8'h3C, 12'h000, 12'h000, 1'b0);
    send_access(CMD_ROM_LOAD, 20'h10000, 16'h0000, 8'h99, 12'h000, 12'h000, 1'b0);
    send_access(CMD_ROM_LOAD, 20'h0FFFF, 16'h0000, 8'h81, 12'h000, 12'h000, 1'b0);
    send_access(CMD_MEM_WR,   20'hF0000, 16'h0000, 8'h00, 12'h000, 12'h000, 1'b0);
    send_access(CMD_MEM_RD,   20'hF0000, 16'h0000, 8'h00, 12'h000, 12'h000, 1'b0);
    send_access(CMD_MEM_RD,   20'hFFFFF, 16'h0000, 8'h00, 12'h000, 12'h000, 1'b0);
    // IO: reads give all ones, only the debug port emits a character.
    send_access(CMD_IO_RD,    20'h00000, 16'hFFFF, 8'h00, 12'h000, 12'h000, 1'b0);
    send_access(CMD_IO_WR,    20'h00000, 16'h00E9, 8'hFF, 12'h000, 12'h000, 1'b0);
    send_access(CMD_IO_WR,    20'h00000, 16'h00E8, 8'h42, 12'h000, 12'h000, 1'b0);
    // Pixels at both screen corners, seen through the VRAM window too.
    send_access(CMD_PIX_WR,   20'h00000, 16'h0000, 8'h00, 12'd0,   12'd0,   1'b1);
    send_access(CMD_PIX_WR,   20'h00000, 16'h0000, 8'h00, 12'd639, 12'd199, 1'b1);
    send_access(CMD_MEM_RD,   20'hB8000, 16'h0000, 8'h00, 12'h000, 12'h000, 1'b0);
    send_access(CMD_PIX_RD,   20'h00000, 16'h0000, 8'h00, 12'd639, 12'd199, 1'b0);
    // Off-screen pixels: writes dropped, reads give zero.
    send_access(CMD_PIX_WR,   20'h00000, 16'h0000, 8'h00, 12'h800, 12'h7FF, 1'b1);
    send_access(CMD_PIX_RD,   20'h00000, 16'h0000, 8'h00, 12'd640, 12'd0,   1'b0);
    send_access(CMD_PIX_RD,   20'h00000, 16'h0000, 8'h00, 12'd0,   12'hFFF, 1'b0);
    // Screen fills with both values, with a clear of one pixel in between.
    send_access(CMD_FILL,     20'h00000, 16'h0000, 8'h00, 12'h000, 12'h000, 1'b1);
    send_access(CMD_MEM_RD,   20'hBBFFF, 16'h0000, 8'h00, 12'h000, 12'h000, 1'b0);
    send_access(CMD_PIX_WR,   20'h00000, 16'h0000, 8'h00, 12'd3,   12'd0,   1'b0);
    send_access(CMD_PIX_RD,   20'h00000, 16'h0000, 8'h00, 12'd3,   12'd0,   1'b0);
    send_access(CMD_FILL,     20'h00000, 16'h0000, 8'h00, 12'h000, 12'h000, 1'b0);

    // Reset map; the receiver holds off partway through while the sender keeps going.
    run_random(100);
    sink_hold_reqs++;
    run_random(170);

    // Narrow mask with the RAM and video RAM windows adjacent, no idling on either side.
    set_bus_map(20'h3FFFF, 20'h10000, 20'h20000, 20'h30000, 16'h0000);
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    run_random(270);
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;

    // Overlapping windows; the sender pauses until the block has emptied.
    set_bus_map(20'hFFFFF, 20'h40000, 20'h4F000, 20'h51000, 16'hFFFF);
    run_random(130);
    drain_results();
    run_random(140);

    // Mask of zero folds every address onto address zero.
    set_bus_map(20'h00000, 20'hFFFFF, 20'h00000, 20'h00000, 16'h8000);
    run_random(200);

    // Windows at the very top and bottom of the address space.
    set_bus_map(20'hFFFFF, 20'hFFFFF, 20'hFC001, 20'h00000, 16'h1234);
    run_random(270);

    // Reset map again, with one address bit masked off.
    set_bus_map(20'hF7FFF, 20'h00000, 20'hB8000, 20'hF0000, 16'h00E9);
    run_random(340);

    drain_results();
    repeat (20) @(negedge clk);

    $display("Ran %0d bus maps: %0d mem reads, %0d mem writes, %0d io reads, %0d io writes,",
             bus_maps, cmd_count[CMD_MEM_RD], cmd_count[CMD_MEM_WR], cmd_count[CMD_IO_RD],
             cmd_count[CMD_IO_WR]);
    $display("%0d rom loads, %0d pixel writes, %0d pixel reads, %0d screen fills; %0d errors.",
             cmd_count[CMD_ROM_LOAD], cmd_count[CMD_PIX_WR], cmd_count[CMD_PIX_RD],
             cmd_count[CMD_FILL], fail_count);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
